// File: hw/rtl/tlnt_pkg.sv
// Shared types and constants for the two-level name table.
// No dependencies; imported by tlnt_ram and two_level_name_table.
package tlnt_pkg;

    localparam int KEY_W    = 72;
    localparam int KEY_LO_W = 64;
    localparam int KEY_HI_W = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int GSLOT_W  = 7;
    localparam int MSLOT_W  = 4;
    localparam int MTOTAL_W = 5;

    localparam int DEF_MAX_GROUPS  = 128;
    localparam int DEF_MAX_MEMBERS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_GROUP_EXISTS   = 3'd1,
        ST_GROUP_MISSING  = 3'd2,
        ST_MEMBER_EXISTS  = 3'd3,
        ST_MEMBER_MISSING = 3'd4,
        ST_GROUPS_FULL    = 3'd5,
        ST_MEMBERS_FULL   = 3'd6
    } status_t;

endpackage

// File: hw/rtl/tlnt_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on tlnt_pkg for the default word width.
module tlnt_ram #(
    parameter int WIDTH = tlnt_pkg::KEY_W,
    parameter int DEPTH = tlnt_pkg::DEF_MAX_GROUPS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import tlnt_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/two_level_name_table.sv
// Two-level name table: controller plus group, count and member RAMs.
// Depends on tlnt_pkg and tlnt_ram.
//
// Usage: one request per s_ transfer (operation, group name, member name),
// one result per m_ transfer (status, group slot, member slot, member total).
// s_ready is high only while no request is in progress; a finished result sits
// in the output register, so the next request is taken while it waits.
// A scan of the group RAM makes one compare per cycle, behind the registered
// read of the group RAM; add, delete and search then scan the member RAM of
// that group in the same way. Deleting a member adds the states S_DRD and S_DWR
// for the move of the last member. The next request is taken in the cycle after
// the result is loaded; the scans run in sequence through the single read port
// of each RAM.
// Reset clears the group total and the handshake state only. RAM contents need
// no clearing: only entries below the group total or a group's count are read,
// and a group's count is written to zero when the group is created.
// If the receiver stalls, the result holds on m_ and a finished request waits
// until the output register is free; no result is dropped.
module two_level_name_table #(
    parameter int MAX_GROUPS  = tlnt_pkg::DEF_MAX_GROUPS,
    parameter int MAX_MEMBERS = tlnt_pkg::DEF_MAX_MEMBERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlnt_pkg::OP_W-1:0]     s_operation,
    input  logic [tlnt_pkg::KEY_LO_W-1:0] s_group_name_low,
    input  logic [tlnt_pkg::KEY_HI_W-1:0] s_group_name_high,
    input  logic [tlnt_pkg::KEY_LO_W-1:0] s_member_name_low,
    input  logic [tlnt_pkg::KEY_HI_W-1:0] s_member_name_high,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlnt_pkg::STATUS_W-1:0] m_status,
    output logic [tlnt_pkg::GSLOT_W-1:0]  m_group_slot,
    output logic [tlnt_pkg::MSLOT_W-1:0]  m_member_slot,
    output logic [tlnt_pkg::MTOTAL_W-1:0] m_member_total
);
    import tlnt_pkg::*;

    localparam int GW  = $clog2(MAX_GROUPS);
    localparam int GTW = $clog2(MAX_GROUPS + 1);
    localparam int MW  = $clog2(MAX_MEMBERS);
    localparam int CW  = $clog2(MAX_MEMBERS + 1);
    localparam int MD  = MAX_GROUPS * MAX_MEMBERS;
    localparam int AW  = $clog2(MD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GSCAN,
        S_GDEC,
        S_MSCAN,
        S_MDEC,
        S_DRD,
        S_DWR,
        S_DONE
    } state_t;

    state_t         state_reg;
    op_t            op_reg;
    logic [KEY_W-1:0] gkey_reg;
    logic [KEY_W-1:0] mkey_reg;
    logic [GTW-1:0] total_reg;
    logic [GTW-1:0] gi_reg;
    logic [GW-1:0]  gc_reg;
    logic [GW-1:0]  g_reg;
    logic           ghit_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  mi_reg;
    logic [MW-1:0]  mc_reg;
    logic [MW-1:0]  m_reg;
    logic           mhit_reg;
    logic           rd_v_reg;
    logic [AW-1:0]  base_reg;

    status_t        res_status_reg;
    logic [GW-1:0]  res_g_reg;
    logic [MW-1:0]  res_m_reg;
    logic [CW-1:0]  res_total_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [GSLOT_W-1:0]  m_gslot_reg;
    logic [MSLOT_W-1:0]  m_mslot_reg;
    logic [MTOTAL_W-1:0] m_total_reg;

    // RAM ports
    logic             grp_we;
    logic [KEY_W-1:0] grp_rdata;
    logic             cnt_we;
    logic [GW-1:0]    cnt_waddr;
    logic [CW-1:0]    cnt_wdata;
    logic [CW-1:0]    cnt_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_rdata;

    logic create_ok;
    logic add_ok;

    assign create_ok = (state_reg == S_GDEC) && (op_reg == OP_CREATE) && !ghit_reg
                       && (total_reg != GTW'(MAX_GROUPS));
    assign add_ok    = (state_reg == S_MDEC) && (op_reg == OP_ADD) && !mhit_reg
                       && (cnt_reg != CW'(MAX_MEMBERS));

    always_comb begin
        grp_we    = create_ok;
        cnt_we    = create_ok || add_ok || (state_reg == S_DWR);
        cnt_waddr = create_ok ? total_reg[GW-1:0] : g_reg;
        if (create_ok) begin
            cnt_wdata = '0;
        end else if (add_ok) begin
            cnt_wdata = cnt_reg + CW'(1);
        end else begin
            cnt_wdata = cnt_reg - CW'(1);
        end
        mem_we = add_ok || (state_reg == S_DWR);
        if (add_ok) begin
            mem_waddr = AW'(base_reg + AW'(cnt_reg));
            mem_wdata = mkey_reg;
        end else begin
            // move the last member into the freed slot
            mem_waddr = AW'(base_reg + AW'(m_reg));
            mem_wdata = mem_rdata;
        end
        if (state_reg == S_DRD) begin
            mem_raddr = AW'(base_reg + AW'(cnt_reg - CW'(1)));
        end else begin
            mem_raddr = AW'(base_reg + AW'(mi_reg));
        end
    end

    tlnt_ram #(.WIDTH(KEY_W), .DEPTH(MAX_GROUPS)) u_group_ram (
        .aclk  (aclk),
        .we    (grp_we),
        .waddr (total_reg[GW-1:0]),
        .wdata (gkey_reg),
        .raddr (gi_reg[GW-1:0]),
        .rdata (grp_rdata)
    );

    tlnt_ram #(.WIDTH(CW), .DEPTH(MAX_GROUPS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (gi_reg[GW-1:0]),
        .rdata (cnt_rdata)
    );

    tlnt_ram #(.WIDTH(KEY_W), .DEPTH(MD)) u_member_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded this cycle
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= op_t'(s_operation);
                        gkey_reg  <= {s_group_name_high, s_group_name_low};
                        mkey_reg  <= {s_member_name_high, s_member_name_low};
                        gi_reg    <= '0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_GSCAN;
                    end
                end
                S_GSCAN: begin
                    // compare the entry read last cycle, issue the next read
                    if (rd_v_reg && (grp_rdata == gkey_reg)) begin
                        g_reg     <= gc_reg;
                        cnt_reg   <= cnt_rdata;
                        ghit_reg  <= 1'b1;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_GDEC;
                    end else if (gi_reg < total_reg) begin
                        gc_reg   <= gi_reg[GW-1:0];
                        gi_reg   <= gi_reg + GTW'(1);
                        rd_v_reg <= 1'b1;
                    end else begin
                        ghit_reg  <= 1'b0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_GDEC;
                    end
                end
                S_GDEC: begin
                    res_m_reg <= '0;
                    if (op_reg == OP_CREATE) begin
                        state_reg <= S_DONE;
                        if (ghit_reg) begin
                            res_status_reg <= ST_GROUP_EXISTS;
                            res_g_reg      <= g_reg;
                            res_total_reg  <= cnt_reg;
                        end else if (!create_ok) begin
                            res_status_reg <= ST_GROUPS_FULL;
                            res_g_reg      <= '0;
                            res_total_reg  <= '0;
                        end else begin
                            res_status_reg <= ST_OK;
                            res_g_reg      <= total_reg[GW-1:0];
                            res_total_reg  <= '0;
                            total_reg      <= total_reg + GTW'(1);
                        end
                    end else if (!ghit_reg) begin
                        res_status_reg <= ST_GROUP_MISSING;
                        res_g_reg      <= '0;
                        res_total_reg  <= '0;
                        state_reg      <= S_DONE;
                    end else begin
                        res_g_reg <= g_reg;
                        base_reg  <= AW'(g_reg * MAX_MEMBERS);
                        mi_reg    <= '0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_MSCAN;
                    end
                end
                S_MSCAN: begin
                    if (rd_v_reg && (mem_rdata == mkey_reg)) begin
                        m_reg     <= mc_reg;
                        mhit_reg  <= 1'b1;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_MDEC;
                    end else if (mi_reg < cnt_reg) begin
                        mc_reg   <= mi_reg[MW-1:0];
                        mi_reg   <= mi_reg + CW'(1);
                        rd_v_reg <= 1'b1;
                    end else begin
                        mhit_reg  <= 1'b0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_MDEC;
                    end
                end
                S_MDEC: begin
                    state_reg     <= S_DONE;
                    res_total_reg <= cnt_reg;
                    if (op_reg == OP_ADD) begin
                        if (mhit_reg) begin
                            res_status_reg <= ST_MEMBER_EXISTS;
                            res_m_reg      <= m_reg;
                        end else if (!add_ok) begin
                            res_status_reg <= ST_MEMBERS_FULL;
                            res_m_reg      <= '0;
                        end else begin
                            res_status_reg <= ST_OK;
                            res_m_reg      <= cnt_reg[MW-1:0];
                            res_total_reg  <= cnt_reg + CW'(1);
                        end
                    end else if (!mhit_reg) begin
                        res_status_reg <= ST_MEMBER_MISSING;
                        res_m_reg      <= '0;
                    end else begin
                        res_status_reg <= ST_OK;
                        res_m_reg      <= m_reg;
                        if (op_reg == OP_DELETE) begin
                            res_total_reg <= cnt_reg - CW'(1);
                            state_reg     <= S_DRD;
                        end
                    end
                end
                S_DRD: begin
                    state_reg <= S_DWR;
                end
                S_DWR: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_gslot_reg  <= GSLOT_W'(res_g_reg);
                        m_mslot_reg  <= MSLOT_W'(res_m_reg);
                        m_total_reg  <= MTOTAL_W'(res_total_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_group_slot   = m_gslot_reg;
    assign m_member_slot  = m_mslot_reg;
    assign m_member_total = m_total_reg;

endmodule
